// File: rtl/mma_pkg.sv
`default_nettype none

package mma_pkg;

    // Item selector codes
    typedef enum logic [2:0] {
        FUNC_WR_A    = 3'd0,
        FUNC_WR_B    = 3'd1,
        FUNC_WR_C    = 3'd2,
        FUNC_COMPUTE = 3'd3,
        FUNC_RD_C    = 3'd4
    } func_t;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS_M  = 2'd0;
    localparam logic [1:0] REG_COLS_N  = 2'd1;
    localparam logic [1:0] REG_INNER_K = 2'd2;
    localparam logic [1:0] REG_ALPHA   = 2'd3;

    // Register reset values
    localparam logic [6:0]         ROWS_M_RST  = 7'd64;
    localparam logic [8:0]         COLS_N_RST  = 9'd256;
    localparam logic [6:0]         INNER_K_RST = 7'd49;
    localparam logic signed [15:0] ALPHA_RST   = 16'sd256;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_A_RD,
        S_A_MUL,
        S_A_RND,
        S_J_RD,
        S_J_MUL,
        S_J_ACC
    } state_t;

endpackage

`default_nettype wire

// File: rtl/matrix_multiply_accumulate_core.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   func, row, col, value
// result    out        result_valid / result_stall  element
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Writes of A, B or C are taken while idle and follow back to back.
// A read of C stalls the input for the registered read, then loads the
// output register; a further read holds while a result still waits.
// A compute stalls the input over the clamped dimensions: per A element it
// reads and scales it by alpha, then multiplies and accumulates per column of C.
// Reset clears control and configuration only; the memories hold no reset value.
module matrix_multiply_accumulate_core #(
    parameter int MAX_M = 64,
    parameter int MAX_N = 256,
    parameter int MAX_K = 64
) (
    input  wire                       clk,
    input  wire                       rst_n,
    // item channel
    input  wire                       item_valid,
    output logic                      item_stall,
    input  wire  [2:0]                func,
    input  wire  [5:0]                row,
    input  wire  [7:0]                col,
    input  wire  signed [31:0]        value,
    // result channel
    output logic                      result_valid,
    input  wire                       result_stall,
    output logic signed [31:0]        element,
    // configuration channel
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [1:0]                cfg_index,
    input  wire  [15:0]               cfg_data
);

    import mma_pkg::*;

    localparam int DEPTH_A = MAX_M * MAX_K;
    localparam int DEPTH_B = MAX_K * MAX_N;
    localparam int DEPTH_C = MAX_M * MAX_N;
    localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
    localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
    localparam int AW_C    = (DEPTH_C > 1) ? $clog2(DEPTH_C) : 1;
    localparam int IW      = $clog2(MAX_M + 1);
    localparam int JW      = $clog2(MAX_N + 1);
    localparam int KW      = $clog2(MAX_K + 1);

    // Matrix stores, row-major
    logic signed [15:0] a_mem [DEPTH_A];
    logic signed [15:0] b_mem [DEPTH_B];
    logic signed [31:0] c_mem [DEPTH_C];

    state_t state_reg, state_next;

    logic [6:0]         rows_m_reg;
    logic [8:0]         cols_n_reg;
    logic [6:0]         inner_k_reg;
    logic signed [15:0] alpha_reg;

    logic [IW-1:0] i_reg, i_next;
    logic [KW-1:0] k_reg, k_next;
    logic [JW-1:0] j_reg, j_next;

    logic [IW-1:0] m_lim;
    logic [KW-1:0] k_lim;
    logic [JW-1:0] n_lim;

    logic signed [31:0] prod_reg;
    logic signed [15:0] part_reg, part_next;
    logic               oob_reg, oob_next;
    logic               result_valid_reg, result_valid_next;
    logic signed [31:0] element_reg, element_next;
    logic               element_load;

    logic signed [15:0] a_rdata_reg;
    logic signed [15:0] b_rdata_reg;
    logic signed [31:0] c_rdata_reg;

    // Memory port controls from the sequencer
    logic               a_we, a_re, b_we, b_re, c_we, c_re;
    logic [AW_A-1:0]    a_waddr, a_raddr;
    logic [AW_B-1:0]    b_waddr, b_raddr;
    logic [AW_C-1:0]    c_waddr, c_raddr;
    logic signed [31:0] c_wdata;

    // Shared multiplier
    logic signed [15:0] mul_x, mul_y;
    logic signed [31:0] mul_p;
    logic               prod_load;

    logic               item_accept;
    logic               in_a, in_b, in_c;
    logic [AW_A-1:0]    item_a_addr, seq_a_addr;
    logic [AW_B-1:0]    item_b_addr, seq_b_addr;
    logic [AW_C-1:0]    item_c_addr, seq_c_addr;

    logic signed [32:0] rnd_sum;
    logic signed [24:0] rnd_q;
    logic signed [15:0] rnd_sat;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic               i_last, k_last, j_last;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign element      = element_reg;

    // Clamp the dimensions to the store sizes
    assign m_lim = (int'(rows_m_reg) > MAX_M)  ? IW'(MAX_M) : IW'(rows_m_reg);
    assign n_lim = (int'(cols_n_reg) > MAX_N)  ? JW'(MAX_N) : JW'(cols_n_reg);
    assign k_lim = (int'(inner_k_reg) > MAX_K) ? KW'(MAX_K) : KW'(inner_k_reg);

    assign i_last = (i_reg + IW'(1)) == m_lim;
    assign k_last = (k_reg + KW'(1)) == k_lim;
    assign j_last = (j_reg + JW'(1)) == n_lim;

    // Address range checks and flat addresses for items
    assign in_a = (int'(row) < MAX_M) && (int'(col) < MAX_K);
    assign in_b = (int'(row) < MAX_K) && (int'(col) < MAX_N);
    assign in_c = (int'(row) < MAX_M) && (int'(col) < MAX_N);

    assign item_a_addr = in_a ? AW_A'(int'(row) * MAX_K + int'(col)) : '0;
    assign item_b_addr = in_b ? AW_B'(int'(row) * MAX_N + int'(col)) : '0;
    assign item_c_addr = in_c ? AW_C'(int'(row) * MAX_N + int'(col)) : '0;

    assign seq_a_addr = AW_A'(int'(i_reg) * MAX_K + int'(k_reg));
    assign seq_b_addr = AW_B'(int'(k_reg) * MAX_N + int'(j_reg));
    assign seq_c_addr = AW_C'(int'(i_reg) * MAX_N + int'(j_reg));

    // Round alpha*A half up to Q8.8 and saturate to 16 bits
    assign rnd_sum = {prod_reg[31], prod_reg} + 33'sd128;
    assign rnd_q   = rnd_sum[32:8];
    always_comb
    begin
        if (rnd_q > 25'sd32767)
            rnd_sat = 16'sh7FFF;
        else if (rnd_q < -25'sd32768)
            rnd_sat = 16'sh8000;
        else
            rnd_sat = rnd_q[15:0];
    end

    // Saturating accumulate of the product term into C
    assign acc_sum = {c_rdata_reg[31], c_rdata_reg} + {prod_reg[31], prod_reg};
    always_comb
    begin
        if (acc_sum[32] != acc_sum[31])
            acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            acc_sat = acc_sum[31:0];
    end

    // One multiplier serves both the alpha scaling and the B products
    always_comb
    begin
        if (state_reg == S_J_MUL)
        begin
            mul_x = part_reg;
            mul_y = b_rdata_reg;
        end
        else
        begin
            mul_x = alpha_reg;
            mul_y = a_rdata_reg;
        end
    end
    assign mul_p = mul_x * mul_y;

    // Sequencer: next state, counters and memory port controls
    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        j_next            = j_reg;
        part_next         = part_reg;
        oob_next          = oob_reg;
        result_valid_next = result_valid_reg && result_stall;
        element_next      = element_reg;
        element_load      = 1'b0;
        prod_load         = 1'b0;
        a_we              = 1'b0;
        a_re              = 1'b0;
        b_we              = 1'b0;
        b_re              = 1'b0;
        c_we              = 1'b0;
        c_re              = 1'b0;
        a_waddr           = item_a_addr;
        a_raddr           = seq_a_addr;
        b_waddr           = item_b_addr;
        b_raddr           = seq_b_addr;
        c_waddr           = item_c_addr;
        c_raddr           = seq_c_addr;
        c_wdata           = value;

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    case (func)
                        FUNC_WR_A:
                            a_we = in_a;
                        FUNC_WR_B:
                            b_we = in_b;
                        FUNC_WR_C:
                            c_we = in_c;
                        FUNC_COMPUTE:
                        begin
                            i_next = '0;
                            k_next = '0;
                            j_next = '0;
                            // a zero dimension leaves C untouched
                            if (m_lim != '0 && n_lim != '0 && k_lim != '0)
                                state_next = S_A_RD;
                        end
                        FUNC_RD_C:
                        begin
                            c_re       = 1'b1;
                            c_raddr    = item_c_addr;
                            oob_next   = !in_c;
                            state_next = S_RD_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                // hold until the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    element_load      = 1'b1;
                    element_next      = oob_reg ? 32'sd0 : c_rdata_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_A_RD:
            begin
                a_re       = 1'b1;
                state_next = S_A_MUL;
            end

            S_A_MUL:
            begin
                prod_load  = 1'b1;
                state_next = S_A_RND;
            end

            S_A_RND:
            begin
                part_next  = rnd_sat;
                j_next     = '0;
                state_next = S_J_RD;
            end

            S_J_RD:
            begin
                b_re       = 1'b1;
                c_re       = 1'b1;
                state_next = S_J_MUL;
            end

            S_J_MUL:
            begin
                prod_load  = 1'b1;
                state_next = S_J_ACC;
            end

            S_J_ACC:
            begin
                c_we    = 1'b1;
                c_waddr = seq_c_addr;
                c_wdata = acc_sat;
                if (!j_last)
                begin
                    j_next     = j_reg + JW'(1);
                    state_next = S_J_RD;
                end
                else if (!k_last)
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_A_RD;
                end
                else if (!i_last)
                begin
                    k_next     = '0;
                    i_next     = i_reg + IW'(1);
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            k_reg            <= '0;
            j_reg            <= '0;
            oob_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            rows_m_reg       <= ROWS_M_RST;
            cols_n_reg       <= COLS_N_RST;
            inner_k_reg      <= INNER_K_RST;
            alpha_reg        <= ALPHA_RST;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            k_reg            <= k_next;
            j_reg            <= j_next;
            oob_reg          <= oob_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS_M:  rows_m_reg  <= cfg_data[6:0];
                    REG_COLS_N:  cols_n_reg  <= cfg_data[8:0];
                    REG_INNER_K: inner_k_reg <= cfg_data[6:0];
                    REG_ALPHA:   alpha_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        if (prod_load)
            prod_reg <= mul_p;
        if (element_load)
            element_reg <= element_next;
    end

    // A store
    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[a_waddr] <= value[15:0];
        if (a_re)
            a_rdata_reg <= a_mem[a_raddr];
    end

    // B store
    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[b_waddr] <= value[15:0];
        if (b_re)
            b_rdata_reg <= b_mem[b_raddr];
    end

    // C store
    always_ff @(posedge clk)
    begin
        if (c_we)
            c_mem[c_waddr] <= c_wdata;
        if (c_re)
            c_rdata_reg <= c_mem[c_raddr];
    end

endmodule

`default_nettype wire

// File: tb/matrix_multiply_accumulate_checker.sv
`timescale 1ns / 100ps

module matrix_multiply_accumulate_checker #(
    parameter int MAX_M = 64,
    parameter int MAX_N = 256,
    parameter int MAX_K = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    input  wire                item_stall,
    input  wire  [2:0]         func,
    input  wire  [5:0]         row,
    input  wire  [7:0]         col,
    input  wire  signed [31:0] value,
    input  wire                result_valid,
    input  wire                result_stall,
    input  wire  signed [31:0] element,
    input  wire                cfg_valid,
    input  wire                cfg_ready,
    input  wire  [1:0]         cfg_index,
    input  wire  [15:0]        cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    import mma_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic signed [15:0] a_mem [0:MAX_M*MAX_K-1];
    logic signed [15:0] b_mem [0:MAX_K*MAX_N-1];
    logic signed [31:0] c_mem [0:MAX_M*MAX_N-1];

    logic [6:0]         rows_q;
    logic [8:0]         cols_q;
    logic [6:0]         inner_q;
    logic signed [15:0] alpha_q;

    logic signed [31:0] expected_elements [$];

    // alpha*A rounded half up to Q8.8, saturated to 16 bits
    function automatic logic signed [15:0] scaled_a(input logic signed [15:0] scale,
                                                    input logic signed [15:0] a_val);
        logic signed [31:0] prod;
        prod = scale * a_val;
        prod = (prod + 32'sd128) >>> 8;
        if (prod > 32'sd32767)
            return 16'sh7FFF;
        if (prod < -32'sd32768)
            return 16'sh8000;
        return prod[15:0];
    endfunction

    // C += alpha*A*B over the clamped dimensions, saturating every addition
    task automatic accumulate_product();
        int m_lim;
        int n_lim;
        int k_lim;
        int i;
        int kk;
        int j;
        logic signed [15:0] part;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        m_lim = (rows_q > MAX_M) ? MAX_M : rows_q;
        n_lim = (cols_q > MAX_N) ? MAX_N : cols_q;
        k_lim = (inner_q > MAX_K) ? MAX_K : inner_q;
        for (i = 0; i < m_lim; i++)
        begin
            for (kk = 0; kk < k_lim; kk++)
            begin
                part = scaled_a(alpha_q, a_mem[i*MAX_K + kk]);
                for (j = 0; j < n_lim; j++)
                begin
                    term = part;
                    term = term * b_mem[kk*MAX_N + j];
                    sum  = c_mem[i*MAX_N + j];
                    sum  = sum + term;
                    if (sum > 64'sd2147483647)
                        sum = 64'sd2147483647;
                    if (sum < -64'sd2147483648)
                        sum = -64'sd2147483648;
                    c_mem[i*MAX_N + j] = sum[31:0];
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%t: %s: expected %0d (%08h), got %0d (%08h)",
                     $realtime, what, want, want, got, got);
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_q  = ROWS_M_RST;
            cols_q  = COLS_N_RST;
            inner_q = INNER_K_RST;
            alpha_q = ALPHA_RST;
        end
        else
        begin
            // results first: an item taken at this edge cannot be answered yet
            if (result_valid && !result_stall)
            begin
                if (expected_elements.size() == 0)
                    note_mismatch("element with none pending", '0, element);
                else if (element !== expected_elements[0])
                    note_mismatch("element mismatch", expected_elements.pop_front(), element);
                else
                    void'(expected_elements.pop_front());
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS_M:  rows_q  = cfg_data[6:0];
                    REG_COLS_N:  cols_q  = cfg_data[8:0];
                    REG_INNER_K: inner_q = cfg_data[6:0];
                    REG_ALPHA:   alpha_q = cfg_data;
                    default: ;
                endcase
            end

            if (item_valid && !item_stall)
            begin
                case (func)
                    FUNC_WR_A:
                        if (row < MAX_M && col < MAX_K)
                            a_mem[row*MAX_K + col] = value[15:0];
                    FUNC_WR_B:
                        if (row < MAX_K && col < MAX_N)
                            b_mem[row*MAX_N + col] = value[15:0];
                    FUNC_WR_C:
                        if (row < MAX_M && col < MAX_N)
                            c_mem[row*MAX_N + col] = value;
                    FUNC_COMPUTE:
                        accumulate_product();
                    FUNC_RD_C:
                        if (row < MAX_M && col < MAX_N)
                            expected_elements.push_back(c_mem[row*MAX_N + col]);
                        else
                            expected_elements.push_back('0);
                    default: ;
                endcase
            end

            outstanding = expected_elements.size();
        end
    end

endmodule

// File: tb/matrix_multiply_accumulate_core_tb.sv
`timescale 1ns / 100ps

module matrix_multiply_accumulate_core_tb;

    import mma_pkg::*;

    localparam int MAX_M          = 64;
    localparam int MAX_N          = 256;
    localparam int MAX_K          = 64;
    // selector codes run up to this bound; those past FUNC_RD_C are unused
    localparam int FUNC_CODES     = 8;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int PHASE_ITEMS    = 60;
    localparam int BURST_READS    = 12;
    // long receiver hold-off, well beyond what fills the read path
    localparam int HOLD_STRETCH   = 300;
    // quiet cycles allowed; well beyond the slowest compute here
    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [2:0]         func;
    logic [5:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] element;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    int mismatches;
    int outstanding;
    int quiet_cycles;

    // Stimulus-side bookkeeping: which entries hold data, and the clamped
    // dimensions currently programmed.
    bit a_wr [0:MAX_M*MAX_K-1];
    bit b_wr [0:MAX_K*MAX_N-1];
    bit c_wr [0:MAX_M*MAX_N-1];
    int c_addrs [$];
    int dim_m;
    int dim_n;
    int dim_k;
    int busy_cycles;
    int items_done;
    int phase_count;

    // Idle pattern state for each side, and the pressure controls
    int item_mode_left;
    bit item_quiet;
    int res_mode_left;
    bit res_quiet;
    bit rush;
    bit hold_request;

    matrix_multiply_accumulate_core #(
        .MAX_M (MAX_M),
        .MAX_N (MAX_N),
        .MAX_K (MAX_K)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .row          (row),
        .col          (col),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .element      (element),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    matrix_multiply_accumulate_checker #(
        .MAX_M (MAX_M),
        .MAX_N (MAX_N),
        .MAX_K (MAX_K)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .row          (row),
        .col          (col),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .element      (element),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Draw the wait before the next item. Every 64 items pick anew between a
    // stretch with no idling at all (one time in three) and one with random gaps.
    function automatic int draw_gap(inout int left, inout bit quiet);
        if (left == 0)
        begin
            left  = 64;
            quiet = ($urandom_range(0, 2) == 0);
        end
        left--;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Data word biased towards the extremes of both the 32-bit and the
    // 16-bit views, since A and B keep only the low half.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_7FFF;
            3:       return 32'hFFFF_8000;
            4:       return 32'($urandom_range(0, 511)) - 32'd256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_alpha();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0100;
            3:       return 16'hFE80;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Half the time pick inside the active region, otherwise anywhere
    function automatic int near_index(input int lim, input int full);
        if (lim > 0 && $urandom_range(0, 1) == 1)
            return $urandom_range(0, lim - 1);
        return $urandom_range(0, full - 1);
    endfunction

    // Offer one item and hold it until taken. Called and left at a falling
    // edge; valid stays high so that a back-to-back item needs no toggle.
    task automatic send_item(input logic [2:0] op, input logic [5:0] r_idx,
                             input logic [7:0] c_idx, input logic [31:0] data);
        int gap;
        gap = draw_gap(item_mode_left, item_quiet);
        if (rush)
            gap = 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func       <= op;
        row        <= r_idx;
        col        <= c_idx;
        value      <= data;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    // Track what becomes defined, count the items that do real work, and
    // note how long a compute keeps the block busy.
    task automatic issue(input logic [2:0] op, input int r_idx, input int c_idx,
                         input logic [31:0] data);
        if (op == FUNC_WR_A && c_idx < MAX_K)
            a_wr[r_idx*MAX_K + c_idx] = 1'b1;
        if (op == FUNC_WR_B)
            b_wr[r_idx*MAX_N + c_idx] = 1'b1;
        if (op == FUNC_WR_C && !c_wr[r_idx*MAX_N + c_idx])
        begin
            c_wr[r_idx*MAX_N + c_idx] = 1'b1;
            c_addrs.push_back(r_idx*MAX_N + c_idx);
        end
        if (op == FUNC_COMPUTE)
            busy_cycles = dim_m * dim_k * (3 + 3*dim_n);
        if (op <= FUNC_RD_C && !(op == FUNC_WR_A && c_idx >= MAX_K))
            items_done++;
        send_item(op, r_idx[5:0], c_idx[7:0], data);
    endtask

    // Drop valid, wait for every read to come back, then let any compute
    // still running finish before the registers are touched.
    task automatic settle();
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (busy_cycles + 16) @(negedge clk);
        busy_cycles = 0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure(input logic [6:0] m_reg, input logic [8:0] n_reg,
                             input logic [6:0] k_reg, input logic [15:0] alpha);
        write_reg(REG_ROWS_M, 16'(m_reg));
        write_reg(REG_COLS_N, 16'(n_reg));
        write_reg(REG_INNER_K, 16'(k_reg));
        write_reg(REG_ALPHA, alpha);
        cfg_valid <= 1'b0;
        dim_m = (m_reg > MAX_M) ? MAX_M : m_reg;
        dim_n = (n_reg > MAX_N) ? MAX_N : n_reg;
        dim_k = (k_reg > MAX_K) ? MAX_K : k_reg;
    endtask

    // Fill every entry the next compute will touch that holds nothing yet, then compute
    task automatic compute_now();
        int i;
        int j;
        int kk;
        for (i = 0; i < dim_m; i++)
            for (kk = 0; kk < dim_k; kk++)
                if (!a_wr[i*MAX_K + kk])
                    issue(FUNC_WR_A, i, kk, rand_word());
        for (kk = 0; kk < dim_k; kk++)
            for (j = 0; j < dim_n; j++)
                if (!b_wr[kk*MAX_N + j])
                    issue(FUNC_WR_B, kk, j, rand_word());
        for (i = 0; i < dim_m; i++)
            for (j = 0; j < dim_n; j++)
                if (!c_wr[i*MAX_N + j])
                    issue(FUNC_WR_C, i, j, rand_word());
        issue(FUNC_COMPUTE, $urandom_range(0, MAX_M - 1), $urandom_range(0, MAX_N - 1),
              $urandom);
    endtask

    // Read a C entry that holds data, preferring the active region
    task automatic read_c();
        int idx;
        idx = near_index(dim_m, MAX_M) * MAX_N + near_index(dim_n, MAX_N);
        if (!c_wr[idx])
            idx = c_addrs[$urandom_range(0, c_addrs.size() - 1)];
        issue(FUNC_RD_C, idx / MAX_N, idx % MAX_N, $urandom);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            issue(FUNC_WR_A, near_index(dim_m, MAX_M), near_index(dim_k, MAX_K), rand_word());
        else if (pick < 40)
            issue(FUNC_WR_B, near_index(dim_k, MAX_K), near_index(dim_n, MAX_N), rand_word());
        else if (pick < 52)
            issue(FUNC_WR_C, near_index(dim_m, MAX_M), near_index(dim_n, MAX_N), rand_word());
        else if (pick < 85)
            read_c();
        else if (pick < 91)
            compute_now();
        else if (pick < 95)
            issue(FUNC_WR_A, $urandom_range(0, MAX_M - 1), $urandom_range(MAX_K, MAX_N - 1),
                  rand_word());
        else
            issue(3'($urandom_range(FUNC_RD_C + 1, FUNC_CODES - 1)),
                  $urandom_range(0, MAX_M - 1), $urandom_range(0, MAX_N - 1), $urandom);
    endtask

    // One setting of the registers: program it while idle, multiply once,
    // then mix random items over it.
    task automatic run_phase(input logic [6:0] m_reg, input logic [8:0] n_reg,
                             input logic [6:0] k_reg, input logic [15:0] alpha,
                             input int count);
        settle();
        configure(m_reg, n_reg, k_reg, alpha);
        compute_now();
        repeat (count) random_item();
    endtask

    // Hold the result side off for a long stretch while reads pour in, so
    // the block fills and stalls its input.
    task automatic back_pressure_burst();
        settle();
        hold_request = 1'b1;
        rush         = 1'b1;
        repeat (BURST_READS) read_c();
        rush         = 1'b0;
    endtask

    // Result side: wait a drawn number of cycles after each item, take the
    // long hold-off when asked, then accept.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(res_mode_left, res_quiet);
            if (hold_request)
            begin
                gap          = HOLD_STRETCH;
                hold_request = 1'b0;
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            @(negedge clk);
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** matrix_multiply_accumulate_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int sel;
        int op;
        logic [6:0] m_reg;
        logic [8:0] n_reg;
        logic [6:0] k_reg;

        rst_n          = 1'b0;
        item_valid     = 1'b0;
        func           = '0;
        row            = '0;
        col            = '0;
        value          = '0;
        result_stall   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        quiet_cycles   = 0;
        busy_cycles    = 0;
        items_done     = 0;
        phase_count    = 0;
        item_mode_left = 0;
        res_mode_left  = 0;
        item_quiet     = 1'b0;
        res_quiet      = 1'b0;
        rush           = 1'b0;
        hold_request   = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 2x2 by 2x3 with alpha -1.5, so the scaled A term rounds
        // a negative half upwards and saturates both ways.
        configure(7'd2, 9'd3, 7'd2, 16'hFE80);
        issue(FUNC_WR_A, 0, 0, 32'h0000_7FFF);
        issue(FUNC_WR_A, 0, 1, 32'hFFFF_8000);
        issue(FUNC_WR_A, 1, 0, 32'h1234_5678);     // upper half dropped
        issue(FUNC_WR_A, 1, 1, 32'hFFFF_0001);
        issue(FUNC_WR_B, 0, 0, 32'h0000_7FFF);
        issue(FUNC_WR_B, 0, 1, 32'h0000_8000);
        issue(FUNC_WR_B, 0, 2, 32'h0000_0001);
        issue(FUNC_WR_B, 1, 0, 32'hFFFF_FFFF);
        issue(FUNC_WR_B, 1, 1, 32'h0000_0100);
        issue(FUNC_WR_B, 1, 2, 32'h7FFF_7FFF);
        issue(FUNC_WR_C, 0, 0, 32'h7FFF_FFFF);     // starts at the positive limit; both terms pull it down
        issue(FUNC_WR_C, 0, 1, 32'h8000_0000);
        issue(FUNC_WR_C, 0, 2, 32'h0000_0000);
        issue(FUNC_WR_C, 1, 0, 32'h0000_0000);
        issue(FUNC_WR_C, 1, 1, 32'h0000_0001);
        issue(FUNC_WR_C, 1, 2, 32'hFFFF_FFFF);
        // A column out of range and the unused selectors must change nothing
        issue(FUNC_WR_A, MAX_M - 1, MAX_N - 1, 32'h0000_7FFF);
        for (op = FUNC_RD_C + 1; op < FUNC_CODES; op++)
            issue(3'(op), MAX_M - 1, MAX_N - 1, 32'hFFFF_FFFF);
        issue(FUNC_COMPUTE, MAX_M - 1, MAX_N - 1, 32'hFFFF_FFFF);
        issue(FUNC_WR_C, MAX_M - 1, MAX_N - 1, 32'h8000_0001);
        issue(FUNC_RD_C, 0, 0, 32'h0);
        issue(FUNC_RD_C, 0, 1, 32'h0);
        issue(FUNC_RD_C, 1, 2, 32'h0);
        issue(FUNC_RD_C, MAX_M - 1, MAX_N - 1, 32'hFFFF_FFFF);

        items_done = 0;

        // Register extremes: each dimension past its maximum (clamped) with
        // the others at one, all three at zero, and alpha at its limits.
        run_phase(7'h7F, 9'd1, 7'd1, 16'h8000, 40);
        run_phase(7'd1, 9'h1FF, 7'd1, 16'h7FFF, 40);
        run_phase(7'd1, 9'd1, 7'h7F, 16'h0001, 40);
        run_phase(7'd0, 9'd0, 7'd0, 16'hFFFF, 40);

        // Random phases: mostly small shapes to keep computes short
        while (items_done < RANDOM_ITEMS)
        begin
            sel   = $urandom_range(0, 11);
            m_reg = 7'($urandom_range(1, 4));
            n_reg = 9'($urandom_range(1, 8));
            k_reg = 7'($urandom_range(1, 4));
            if (sel == 0)
            begin
                m_reg = 7'($urandom_range(MAX_M, 127));
                n_reg = 9'd1;
                k_reg = 7'd1;
            end
            else if (sel == 1)
            begin
                m_reg = 7'd1;
                n_reg = 9'($urandom_range(MAX_N, 511));
                k_reg = 7'd1;
            end
            else if (sel == 2)
            begin
                m_reg = 7'd1;
                n_reg = 9'd1;
                k_reg = 7'($urandom_range(MAX_K, 127));
            end
            else if (sel == 3)
                k_reg = 7'd0;
            run_phase(m_reg, n_reg, k_reg, rand_alpha(), PHASE_ITEMS);
            phase_count++;
            if (phase_count % 8 == 2)
                back_pressure_burst();
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("** matrix_multiply_accumulate_core: PASSED **");
        else
            $display("** matrix_multiply_accumulate_core: FAILED **");
        $finish;
    end

endmodule
